// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the binary weight multiply RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bwmm_pkg.sv =====
// Shared types and constants of the binary weight matrix multiply unit.
// Used by the channel interfaces and every module of the block.
package bwmm_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_DEPTH_DEF   = 1024;

    localparam int STORE_BYTES = 8192;
    localparam int STORE_AW    = 13;
    localparam int SUM_W       = 26;
    localparam int ACT_W       = 16;
    localparam int SCALE_W     = 16;
    localparam int RESULT_W    = 42;
    localparam int COLIDX_W    = 6;
    localparam int COLCNT_W    = 7;
    localparam int DEPTHCNT_W  = 11;
    localparam int ROWCNT_W    = 16;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;

    localparam logic [SCALE_W-1:0]    SCALE_RST     = 16'd256;
    localparam logic [COLCNT_W-1:0]   COLCNT_RST    = 7'd64;
    localparam logic [DEPTHCNT_W-1:0] DEPTHCNT_RST  = 11'd1024;
    localparam logic [ROWCNT_W-1:0]   ROWCNT_RST    = 16'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ACT  = 1'b1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_WEIGHT_SCALE = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_DEPTH_COUNT  = 2'd2,
        CFG_ROW_COUNT    = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [COLIDX_W-1:0]     col;
        logic                    row_last;
        logic                    matrix_last;
    } t_drain_word;

endpackage

// ===== hdl/bwmm_ifs.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on bwmm_pkg for the payload widths.
interface bwmm_in_if import bwmm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [STORE_AW-1:0]     weight_index;
    logic [7:0]              weight_byte;
    logic signed [ACT_W-1:0] act_value;

    modport source (
        output valid, kind, weight_index, weight_byte, act_value,
        input  ready
    );
    modport sink (
        input  valid, kind, weight_index, weight_byte, act_value,
        output ready
    );
endinterface

interface bwmm_out_if import bwmm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result_value;
    logic [COLIDX_W-1:0]        column_index;
    logic                       row_last;
    logic                       matrix_last;

    modport source (
        output valid, result_value, column_index, row_last, matrix_last,
        input  ready
    );
    modport sink (
        input  valid, result_value, column_index, row_last, matrix_last,
        output ready
    );
endinterface

// ===== hdl/bwmm_cell.sv =====
// One column accumulator of the rotating accumulator ring.
// Depends on bwmm_pkg for the accumulator width.
module bwmm_cell import bwmm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= i_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/bwmm_wmem.sv =====
// Packed weight store with one write port and one registered read port.
// Depends on bwmm_pkg for the store size.
module bwmm_wmem import bwmm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [STORE_AW-1:0] i_waddr,
    input  logic [7:0]          i_wdata,
    input  logic [STORE_AW-1:0] i_raddr,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bwmm_out.sv =====
// Result path: operand register, scale multiplier and output word register.
// Depends on bwmm_pkg and the bwmm_out_if channel interface.
module bwmm_out import bwmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SCALE_W-1:0] i_scale,
    input  t_drain_word        i_word,
    output logic               o_take,
    bwmm_out_if.source         o_out
);

    t_drain_word                r_a;
    logic                       r_o_valid;
    logic signed [RESULT_W-1:0] r_o_value;
    logic [COLIDX_W-1:0]        r_o_col;
    logic                       r_o_row_last;
    logic                       r_o_matrix_last;
    logic                       w_en;
    logic signed [SUM_W+SCALE_W:0] w_prod;

    assign w_en   = !r_o_valid || o_out.ready;
    assign o_take = w_en;
    assign w_prod = $signed(r_a.sum) * $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_a.valid <= i_word.valid;
            r_o_valid <= r_a.valid;
        end
        if (w_en) begin
            r_a.sum         <= i_word.sum;
            r_a.col         <= i_word.col;
            r_a.row_last    <= i_word.row_last;
            r_a.matrix_last <= i_word.matrix_last;
            r_o_value       <= w_prod[RESULT_W-1:0];
            r_o_col         <= r_a.col;
            r_o_row_last    <= r_a.row_last;
            r_o_matrix_last <= r_a.matrix_last;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.result_value = r_o_value;
    assign o_out.column_index = r_o_col;
    assign o_out.row_last     = r_o_row_last;
    assign o_out.matrix_last  = r_o_matrix_last;

endmodule

// ===== hdl/binary_weight_matrix_multiply_unit.sv =====
// A weight load word is written to the store when accepted, and input stays ready. After an
// activation word is accepted, input is held off while the ring rotates once past the store port.
// After a row's last activation the ring rotates once more to drain, holding while the output
// stalls; each result passes the operand and output word registers after its column passes.
// Synchronous active-low reset clears accumulators, positions and configuration to
// their defaults; the weight store is not cleared and needs no clearing pass.
`include "assert_macros.svh"
module binary_weight_matrix_multiply_unit import bwmm_pkg::*; #(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    bwmm_in_if.sink           i_in,
    bwmm_out_if.source        o_out
);

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int DPOS_W = $clog2(MAX_DEPTH);
    localparam int DEFF_W = $clog2(MAX_DEPTH + 1);
    localparam int FLAT_W = $clog2(MAX_DEPTH) + $clog2(MAX_COLUMNS);

    logic [SCALE_W-1:0]      r_scale;
    logic [COLCNT_W-1:0]     r_col_count;
    logic [DEPTHCNT_W-1:0]   r_depth_count;
    logic [ROWCNT_W-1:0]     r_row_count;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [FLAT_W-1:0]       r_flat, n_flat;
    logic [2:0]              r_bsel;
    logic signed [ACT_W-1:0] r_act;
    logic [DPOS_W-1:0]       r_dpos;
    logic [ROWCNT_W-1:0]     r_rpos;
    logic                    r_row_end;
    logic                    r_mat_end;

    logic [CNT_W-1:0]        w_ncols;
    logic [DEFF_W-1:0]       w_depth;
    logic [ROWCNT_W-1:0]     w_rows;
    logic                    w_row_end;
    logic                    w_mat_end;
    logic                    w_in_acc;
    logic                    w_act_acc;
    logic [DPOS_W+CNT_W-1:0] w_base;
    logic [7:0]              w_rdata;
    logic                    w_bit;
    logic                    w_rotate;
    logic                    w_take;
    logic signed [SUM_W-1:0] w_head;
    logic signed [SUM_W-1:0] w_feedback;
    logic signed [SUM_W-1:0] w_cell_in  [MAX_COLUMNS];
    logic signed [SUM_W-1:0] w_cell_out [MAX_COLUMNS];
    t_drain_word             w_drain;

    function automatic logic signed [SUM_W-1:0] sat_update(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [ACT_W-1:0] act,
        input logic                    plus
    );
        logic signed [SUM_W:0] wide;
        wide = plus ? (SUM_W+1)'(sum) + (SUM_W+1)'(act)
                    : (SUM_W+1)'(sum) - (SUM_W+1)'(act);
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return wide[SUM_W-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale       <= SCALE_RST;
            r_col_count   <= COLCNT_RST;
            r_depth_count <= DEPTHCNT_RST;
            r_row_count   <= ROWCNT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WEIGHT_SCALE: r_scale       <= i_cfg_data[SCALE_W-1:0];
                CFG_COLUMN_COUNT: r_col_count   <= i_cfg_data[COLCNT_W-1:0];
                CFG_DEPTH_COUNT:  r_depth_count <= i_cfg_data[DEPTHCNT_W-1:0];
                CFG_ROW_COUNT:    r_row_count   <= i_cfg_data[ROWCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_col_count == '0) begin
            w_ncols = CNT_W'(1);
        end else if (r_col_count > MAX_COLUMNS) begin
            w_ncols = CNT_W'(MAX_COLUMNS);
        end else begin
            w_ncols = CNT_W'(r_col_count);
        end
        if (r_depth_count == '0) begin
            w_depth = DEFF_W'(1);
        end else if (r_depth_count > MAX_DEPTH) begin
            w_depth = DEFF_W'(MAX_DEPTH);
        end else begin
            w_depth = DEFF_W'(r_depth_count);
        end
        w_rows = (r_row_count == '0) ? ROWCNT_W'(1) : r_row_count;
    end

    assign w_row_end = ({1'b0, r_dpos} + 1'b1) >= w_depth;
    assign w_mat_end = ({1'b0, r_rpos} + 1'b1) >= {1'b0, w_rows};
    assign w_base    = r_dpos * w_ncols;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_act_acc  = w_in_acc && (i_in.kind == KIND_ACT);

    bwmm_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_in.kind == KIND_LOAD)),
        .i_waddr (i_in.weight_index),
        .i_wdata (i_in.weight_byte),
        .i_raddr (STORE_AW'(r_flat >> 3)),
        .o_rdata (w_rdata)
    );

    assign w_bit  = w_rdata[r_bsel];
    assign w_head = w_cell_out[0];

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_ring
        if (g == MAX_COLUMNS - 1) begin : g_tail
            assign w_cell_in[g] = w_feedback;
        end else begin : g_link
            assign w_cell_in[g] = w_cell_out[g+1];
        end
        bwmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_rotate),
            .i_sum   (w_cell_in[g]),
            .o_sum   (w_cell_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dpos  <= '0;
            r_rpos  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_act_acc) begin
                r_dpos <= w_row_end ? '0 : r_dpos + 1'b1;
                if (w_row_end) begin
                    r_rpos <= w_mat_end ? '0 : r_rpos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flat <= n_flat;
        r_bsel <= r_flat[2:0];
        if (w_act_acc) begin
            r_act     <= i_in.act_value;
            r_row_end <= w_row_end;
            r_mat_end <= w_row_end && w_mat_end;
        end
    end

    always_comb begin
        n_state             = r_state;
        n_cnt               = r_cnt;
        n_flat              = r_flat;
        w_rotate            = 1'b0;
        w_feedback          = w_head;
        w_drain.valid       = 1'b0;
        w_drain.sum         = w_head;
        w_drain.col         = COLIDX_W'(r_cnt);
        w_drain.row_last    = ({1'b0, r_cnt} + 1'b1) == w_ncols;
        w_drain.matrix_last = w_drain.row_last && r_mat_end;
        unique case (r_state)
            ST_IDLE: begin
                if (w_act_acc) begin
                    n_state = ST_ACC;
                    n_cnt   = '0;
                    n_flat  = FLAT_W'(w_base);
                end
            end
            ST_ACC: begin
                n_flat = r_flat + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    w_rotate = 1'b1;
                    if ((r_cnt - 1'b1) < w_ncols) begin
                        w_feedback = sat_update(w_head, r_act, w_bit);
                    end
                end
                if (r_cnt == CNT_W'(MAX_COLUMNS)) begin
                    n_cnt   = '0;
                    n_state = r_row_end ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                w_feedback = '0;
                if (r_cnt >= w_ncols) begin
                    w_rotate = 1'b1;
                end else if (w_take) begin
                    w_rotate      = 1'b1;
                    w_drain.valid = 1'b1;
                end
                if (w_rotate) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAX_COLUMNS - 1)) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    bwmm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_scale),
        .i_word  (w_drain),
        .o_take  (w_take),
        .o_out   (o_out)
    );

    // An accepted activation always starts a fresh pass over the ring.
    `ASSERT_NEXT(a_act_starts_pass, i_clk, i_rst_n, w_act_acc, (r_state == ST_ACC) && (r_cnt == '0))
    // The ring leaves the drain only after a full rotation, so it stays aligned.
    `ASSERT_IMPLY(a_drain_full_turn, i_clk, i_rst_n, (r_state == ST_DRAIN) && (n_state == ST_IDLE), r_cnt == CNT_W'(MAX_COLUMNS - 1))
    // The last word of a row carries the last column in use.
    `ASSERT_IMPLY(a_row_last_col, i_clk, i_rst_n, o_out.valid && o_out.row_last, ({1'b0, o_out.column_index} + 1'b1) == w_ncols)
    // The end of a matrix is always also the end of a row.
    `ASSERT_IMPLY(a_mat_last_row, i_clk, i_rst_n, o_out.valid && o_out.matrix_last, o_out.row_last)

endmodule
